@@ design/ttx_enc_pkg.sv @@
// Shared codes, sizes and encode functions for the teletext byte encoder.
`default_nettype none

package ttx_enc_pkg;

  // Function codes carried in the func field
  localparam logic [1:0] FUNC_PARITY  = 2'd0;
  localparam logic [1:0] FUNC_HAM84   = 2'd1;
  localparam logic [1:0] FUNC_HAM2418 = 2'd2;

  // Valid byte counts per result
  localparam logic [1:0] COUNT_NONE   = 2'd0;
  localparam logic [1:0] COUNT_SINGLE = 2'd1;
  localparam logic [1:0] COUNT_TRIPLE = 2'd3;

  localparam int FUNC_W  = 2;
  localparam int LOW_W   = 7;
  localparam int MID_W   = 6;
  localparam int HIGH_W  = 6;
  localparam int CODED_W = 24;
  localparam int COUNT_W = 2;

  // Hamming 8/4 code words, indexed by nibble
  localparam logic [7:0] HAM84_CODE [16] = '{
    8'h15, 8'h02, 8'h49, 8'h5e, 8'h64, 8'h73, 8'h38, 8'h2f,
    8'hd0, 8'hc7, 8'h8c, 8'h9b, 8'ha1, 8'hb6, 8'hfd, 8'hea
  };

  // Coverage of P1..P5 over triplet bits 22:0 (bit k is standard position k+1)
  localparam logic [22:0] HAM2418_MASK [5] = '{
    23'h555555, 23'h666666, 23'h787878, 23'h007f80, 23'h7f8000
  };

  // Odd-parity character: bit 7 set when the low seven bits have even weight
  function automatic logic [7:0] odd_parity_char(input logic [6:0] ch);
    odd_parity_char = {~(^ch), ch};
  endfunction

  // Hamming 24/18 triplet with odd parity groups and overall odd parity in P6
  function automatic logic [23:0] ham2418_encode(input logic [17:0] d);
    logic [23:0] w;
    w        = '0;
    w[2]     = d[0];
    w[6:4]   = d[3:1];
    w[14:8]  = d[10:4];
    w[22:16] = d[17:11];
    // Parity bits sit alone in their groups, so each is set independently
    for (int k = 0; k < 5; k++) begin
      w[(1 << k) - 1] = ~(^(w[22:0] & HAM2418_MASK[k]));
    end
    w[23] = ~(^w[22:0]);
    return w;
  endfunction

endpackage

`default_nettype wire

@@ design/ttx_enc_encode.sv @@
// Combinational encode of one transmission unit for the selected function.
`default_nettype none

module ttx_enc_encode
  import ttx_enc_pkg::*;
(
  input  wire logic [FUNC_W-1:0]  func,
  input  wire logic [LOW_W-1:0]   low_part,
  input  wire logic [MID_W-1:0]   mid_part,
  input  wire logic [HIGH_W-1:0]  high_part,
  output logic      [CODED_W-1:0] coded_bytes,
  output logic      [COUNT_W-1:0] byte_count
);

  logic [7:0]  par_byte;
  logic [7:0]  ham84_byte;
  logic [23:0] triplet;

  assign par_byte   = odd_parity_char(low_part);
  assign ham84_byte = HAM84_CODE[low_part[3:0]];
  assign triplet    = ham2418_encode({high_part, mid_part, low_part[5:0]});

  // Pick the code by function; an undefined code yields no bytes
  always_comb begin
    case (func)
      FUNC_PARITY: begin
        coded_bytes = {16'h0000, par_byte};
        byte_count  = COUNT_SINGLE;
      end
      FUNC_HAM84: begin
        coded_bytes = {16'h0000, ham84_byte};
        byte_count  = COUNT_SINGLE;
      end
      FUNC_HAM2418: begin
        coded_bytes = triplet;
        byte_count  = COUNT_TRIPLE;
      end
      default: begin
        coded_bytes = '0;
        byte_count  = COUNT_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/teletext_t42_byte_encoder_core.sv @@
// Top level: input register, encoder logic and result register of the T42 byte encoder.
//
//   Channel | Direction | Handshake         | Payload
//   in_     | input     | in_valid/in_stall | func, low_part, mid_part, high_part
//   out_    | output    | out_valid/out_stall | coded_bytes, byte_count
//
// A beat loads the input register at acceptance and moves into the result register once
// that register is empty or being taken; one beat per cycle while out_stall stays low.
// The single encode stage sits between the two registers.
// Reset (rst_n low, synchronous) empties both registers.
// out_stall holds the result register; the input register drains into it
// whenever it is empty or being taken, and in_stall rises only when both are held.
`default_nettype none

module teletext_t42_byte_encoder_core
  import ttx_enc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [FUNC_W-1:0]  in_func,
  input  wire logic [LOW_W-1:0]   in_low_part,
  input  wire logic [MID_W-1:0]   in_mid_part,
  input  wire logic [HIGH_W-1:0]  in_high_part,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [CODED_W-1:0]      out_coded_bytes,
  output logic [COUNT_W-1:0]      out_byte_count
);

  logic                s1_valid_r;
  logic [FUNC_W-1:0]   s1_func_r;
  logic [LOW_W-1:0]    s1_low_r;
  logic [MID_W-1:0]    s1_mid_r;
  logic [HIGH_W-1:0]   s1_high_r;
  logic                out_valid_r;
  logic [CODED_W-1:0]  out_coded_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [CODED_W-1:0]  coded_nxt;
  logic [COUNT_W-1:0]  count_nxt;
  logic                out_load;
  logic                s1_load;

  // Advance when the next stage is empty or being drained
  assign out_load = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || out_load;
  assign in_stall = !s1_load;

  ttx_enc_encode u_encode (
    .func        (s1_func_r),
    .low_part    (s1_low_r),
    .mid_part    (s1_mid_r),
    .high_part   (s1_high_r),
    .coded_bytes (coded_nxt),
    .byte_count  (count_nxt)
  );

  // Input register: valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  // Input register: payload
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_func_r <= in_func;
      s1_low_r  <= in_low_part;
      s1_mid_r  <= in_mid_part;
      s1_high_r <= in_high_part;
    end
  end

  // Result register: valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_coded_r <= coded_nxt;
      out_count_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_coded_bytes = out_coded_r;
  assign out_byte_count  = out_count_r;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for the teletext T42 byte encoder: random and directed beats against a local encoder.
`timescale 1ns / 100ps

module tb_top;
  import ttx_enc_pkg::*;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [LOW_W-1:0]  low_part;
    logic [MID_W-1:0]  mid_part;
    logic [HIGH_W-1:0] high_part;
  } ttx_unit_t;

  typedef struct packed {
    logic [CODED_W-1:0] coded_bytes;
    logic [COUNT_W-1:0] byte_count;
  } ttx_code_t;

  localparam int RANDOM_UNITS = 1050;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  // Function code with no encoding behind it
  localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FUNC_W-1:0]  in_func = '0;
  logic [LOW_W-1:0]   in_low_part = '0;
  logic [MID_W-1:0]   in_mid_part = '0;
  logic [HIGH_W-1:0]  in_high_part = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CODED_W-1:0] out_coded_bytes;
  logic [COUNT_W-1:0] out_byte_count;

  ttx_unit_t unit_queue [$];
  ttx_code_t code_queue [$];
  ttx_unit_t next_unit;
  ttx_code_t got_code;
  ttx_code_t want_code;

  int n_total = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int cycle_count = 0;
  int func_seen [4] = '{0, 0, 0, 0};

  teletext_t42_byte_encoder_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_low_part     (in_low_part),
    .in_mid_part     (in_mid_part),
    .in_high_part    (in_high_part),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_coded_bytes (out_coded_bytes),
    .out_byte_count  (out_byte_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hamming 8/4 byte: P1 D1 P2 D2 P3 D3 P4 D4 from bit 0 up, all groups odd
  function automatic logic [7:0] hamming84_byte(input logic [3:0] nib);
    logic p1, p2, p3, p4;
    p1 = ~(nib[0] ^ nib[2] ^ nib[3]);
    p2 = ~(nib[0] ^ nib[1] ^ nib[3]);
    p3 = ~(nib[0] ^ nib[1] ^ nib[2]);
    p4 = ~(p1 ^ nib[0] ^ p2 ^ nib[1] ^ p3 ^ nib[2] ^ nib[3]);
    return {nib[3], p4, nib[2], p3, nib[1], p2, nib[0], p1};
  endfunction

  // Hamming 24/18 triplet: data fills the non-power-of-two positions 1..23
  function automatic logic [23:0] hamming2418_word(input logic [17:0] data);
    logic [23:0] word;
    logic        par;
    int          pos;
    int          k;
    int          next_bit;
    word = '0;
    next_bit = 0;
    for (pos = 1; pos <= 23; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        word[pos-1] = data[next_bit];
        next_bit++;
      end
    end
    // Each check position is the only check bit inside its own group
    for (k = 0; k < 5; k++) begin
      par = 1'b0;
      for (pos = 1; pos <= 23; pos++) begin
        if ((pos & (1 << k)) != 0) par ^= word[pos-1];
      end
      word[(1 << k) - 1] = ~par;
    end
    word[23] = ~(^word[22:0]);
    return word;
  endfunction

  function automatic ttx_code_t encode_unit(input ttx_unit_t u);
    ttx_code_t c;
    c = '0;
    case (u.func)
      FUNC_PARITY: begin
        c.coded_bytes[6:0] = u.low_part;
        c.coded_bytes[7]   = ($countones(u.low_part) % 2) == 0;
        c.byte_count       = COUNT_SINGLE;
      end
      FUNC_HAM84: begin
        c.coded_bytes[7:0] = hamming84_byte(u.low_part[3:0]);
        c.byte_count       = COUNT_SINGLE;
      end
      FUNC_HAM2418: begin
        c.coded_bytes = hamming2418_word({u.high_part, u.mid_part, u.low_part[5:0]});
        c.byte_count  = COUNT_TRIPLE;
      end
      default: begin
        c.byte_count = COUNT_NONE;
      end
    endcase
    return c;
  endfunction

  // Idle mix by run third: sender light/receiver heavy, swapped, then none
  function automatic int sender_idle_pct();
    if (n_accepted * 3 < n_total) return 13;
    if (n_accepted * 3 < n_total * 2) return 47;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (n_accepted * 3 < n_total) return 47;
    if (n_accepted * 3 < n_total * 2) return 13;
    return 0;
  endfunction

  task automatic add_unit(input logic [FUNC_W-1:0] f, input logic [LOW_W-1:0] lo,
                          input logic [MID_W-1:0] mi, input logic [HIGH_W-1:0] hi);
    ttx_unit_t u;
    u.func      = f;
    u.low_part  = lo;
    u.mid_part  = mi;
    u.high_part = hi;
    unit_queue.push_back(u);
  endtask

  task automatic note_mismatch(input string what, input ttx_code_t want, input ttx_code_t got);
    n_errors++;
    if (n_errors <= REPORT_MAX)
      $display("tb: %s at cycle %0d: expected bytes %06h count %0d, got bytes %06h count %0d",
               what, cycle_count, want.coded_bytes, want.byte_count,
               got.coded_bytes, got.byte_count);
  endtask

  // Driver: record accepted beats, then hold, advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        code_queue.push_back(encode_unit({in_func, in_low_part, in_mid_part, in_high_part}));
        func_seen[in_func]++;
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (unit_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          next_unit = unit_queue.pop_front();
          in_func      <= next_unit.func;
          in_low_part  <= next_unit.low_part;
          in_mid_part  <= next_unit.mid_part;
          in_high_part <= next_unit.high_part;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_code.coded_bytes = out_coded_bytes;
        got_code.byte_count  = out_byte_count;
        if (code_queue.size() == 0) begin
          note_mismatch("unexpected result", '0, got_code);
        end else begin
          want_code = code_queue.pop_front();
          if (got_code.coded_bytes !== want_code.coded_bytes ||
              got_code.byte_count !== want_code.byte_count)
            note_mismatch("mismatch", want_code, got_code);
          n_checked++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int i;
    int pick;
    logic [FUNC_W-1:0] f;

    // Parity characters: weight extremes, ignored upper fields
    add_unit(FUNC_PARITY, 7'h00, 6'h00, 6'h00);
    add_unit(FUNC_PARITY, 7'h7f, 6'h3f, 6'h3f);
    add_unit(FUNC_PARITY, 7'h01, 6'h00, 6'h00);
    add_unit(FUNC_PARITY, 7'h03, 6'h2a, 6'h15);
    add_unit(FUNC_PARITY, 7'h55, 6'h15, 6'h2a);
    // Hamming 8/4: extreme nibbles and nibbles with extra high bits set
    add_unit(FUNC_HAM84, 7'h00, 6'h00, 6'h00);
    add_unit(FUNC_HAM84, 7'h0f, 6'h3f, 6'h3f);
    add_unit(FUNC_HAM84, 7'h05, 6'h00, 6'h00);
    add_unit(FUNC_HAM84, 7'h0a, 6'h00, 6'h00);
    add_unit(FUNC_HAM84, 7'h70, 6'h2a, 6'h15);
    add_unit(FUNC_HAM84, 7'h7f, 6'h3f, 6'h3f);
    // Hamming 24/18: all zero, all one, single data bits, bit six alone
    add_unit(FUNC_HAM2418, 7'h00, 6'h00, 6'h00);
    add_unit(FUNC_HAM2418, 7'h7f, 6'h3f, 6'h3f);
    add_unit(FUNC_HAM2418, 7'h01, 6'h00, 6'h00);
    add_unit(FUNC_HAM2418, 7'h00, 6'h00, 6'h20);
    add_unit(FUNC_HAM2418, 7'h40, 6'h00, 6'h00);
    add_unit(FUNC_HAM2418, 7'h3f, 6'h00, 6'h00);
    add_unit(FUNC_HAM2418, 7'h2a, 6'h15, 6'h2a);
    add_unit(FUNC_HAM2418, 7'h00, 6'h3f, 6'h00);
    // Undefined function code
    add_unit(FUNC_UNDEF, 7'h00, 6'h00, 6'h00);
    add_unit(FUNC_UNDEF, 7'h7f, 6'h3f, 6'h3f);
    add_unit(FUNC_UNDEF, 7'h2a, 6'h15, 6'h2a);

    // Random beats: mostly defined codes, a few undefined
    for (i = 0; i < RANDOM_UNITS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) f = FUNC_PARITY;
      else if (pick < 6) f = FUNC_HAM84;
      else if (pick < 9) f = FUNC_HAM2418;
      else f = FUNC_UNDEF;
      add_unit(f, LOW_W'($urandom_range(0, 127)), MID_W'($urandom_range(0, 63)),
               HIGH_W'($urandom_range(0, 63)));
    end
    n_total = unit_queue.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Drain stimulus and predictions, then give the pipeline time to settle
    while (unit_queue.size() != 0 || in_valid || code_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d beats accepted (parity %0d, ham 8/4 %0d, ham 24/18 %0d, undefined %0d)",
             n_accepted, func_seen[FUNC_PARITY], func_seen[FUNC_HAM84],
             func_seen[FUNC_HAM2418], func_seen[FUNC_UNDEF]);
    $display("tb: %0d results checked, %0d mismatches, %0d cycles",
             n_checked, n_errors, cycle_count);
    if (n_errors == 0 && code_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/ttx_enc_pkg.sv
design/ttx_enc_encode.sv
design/teletext_t42_byte_encoder_core.sv
test/tb_top.sv
